/* src/ccl_pkg.sv */
package ccl_pkg;

    localparam logic [7:0] CTRL_MARK  = 8'hEF;
    localparam logic [7:0] WIDE_START = 8'hF1;
    localparam logic [7:0] SECURE_LOW = 8'h00;

    typedef enum logic [1:0] {
        MODE_INSECURE = 2'd0,
        MODE_CONTROL  = 2'd1,
        MODE_SECURE   = 2'd2
    } mode_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } list_beat_t;

    typedef struct packed {
        logic [15:0] class_value;
        logic        class_valid;
        logic        secure_class;
        logic        end_of_list;
        logic [7:0]  insecure_total;
        logic [7:0]  secure_total;
        logic        truncated;
    } class_beat_t;

endpackage

/* src/ccl_stream_if.sv */
interface ccl_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

/* src/ccl_in_reg.sv */
module ccl_in_reg
    import ccl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ccl_stream_if.sink  list_beat,
    input  logic        advance,
    output logic        beat_valid,
    output list_beat_t  beat
);

    logic       valid_reg;
    list_beat_t beat_reg;
    logic       take;

    // slot frees up when the parser consumes the held beat
    assign list_beat.ready = !valid_reg || advance;
    assign take            = list_beat.valid && list_beat.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            beat_reg <= list_beat.payload;
        end
    end

    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

endmodule

/* src/ccl_parser.sv */
module ccl_parser
    import ccl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  list_beat_t  beat,
    output class_beat_t result,
    output logic        emit
);

    mode_t      mode_reg,     mode_next;
    logic       pending_reg,  pending_next;
    logic [7:0] held_reg,     held_next;
    logic [7:0] ins_cnt_reg,  ins_cnt_next;
    logic [7:0] sec_cnt_reg,  sec_cnt_next;

    logic        have;
    logic        listed;
    logic        is_secure;
    logic        trunc;
    logic [15:0] cls;

    always_comb
    begin
        mode_next    = mode_reg;
        pending_next = pending_reg;
        held_next    = held_reg;
        ins_cnt_next = ins_cnt_reg;
        sec_cnt_next = sec_cnt_reg;
        have         = 1'b0;
        listed       = 1'b0;
        is_secure    = 1'b0;
        trunc        = 1'b0;
        cls          = 16'h0000;

        if (pending_reg)
        begin
            // second byte of a pair forms the class with the held byte, or selects secure mode if SECURE_LOW
            pending_next = 1'b0;
            held_next    = 8'h00;
            if (beat.data_byte == SECURE_LOW)
            begin
                mode_next = MODE_SECURE;
            end
            else
            begin
                cls  = {held_reg, beat.data_byte};
                have = 1'b1;
            end
        end
        else if (beat.data_byte >= WIDE_START)
        begin
            // a pair opened on the final byte is dropped
            if (beat.last_byte)
            begin
                trunc = 1'b1;
            end
            else
            begin
                pending_next = 1'b1;
                held_next    = beat.data_byte;
            end
        end
        else if (beat.data_byte == CTRL_MARK)
        begin
            mode_next = MODE_CONTROL;
        end
        else
        begin
            cls  = {8'h00, beat.data_byte};
            have = 1'b1;
        end

        if (have)
        begin
            case (mode_next)
                MODE_INSECURE:
                begin
                    ins_cnt_next = ins_cnt_reg + 8'd1;
                    listed       = 1'b1;
                end
                MODE_SECURE:
                begin
                    sec_cnt_next = sec_cnt_reg + 8'd1;
                    listed       = 1'b1;
                    is_secure    = 1'b1;
                end
                default:
                begin
                    listed = 1'b0;
                end
            endcase
        end

        result.class_value    = listed ? cls : 16'h0000;
        result.class_valid    = listed;
        result.secure_class   = is_secure;
        result.end_of_list    = beat.last_byte;
        result.insecure_total = ins_cnt_next;
        result.secure_total   = sec_cnt_next;
        result.truncated      = trunc;
        emit                  = listed || beat.last_byte;

        if (beat.last_byte)
        begin
            mode_next    = MODE_INSECURE;
            pending_next = 1'b0;
            held_next    = 8'h00;
            ins_cnt_next = 8'h00;
            sec_cnt_next = 8'h00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_INSECURE;
            pending_reg <= 1'b0;
            held_reg    <= 8'h00;
            ins_cnt_reg <= 8'h00;
            sec_cnt_reg <= 8'h00;
        end
        else if (step)
        begin
            mode_reg    <= mode_next;
            pending_reg <= pending_next;
            held_reg    <= held_next;
            ins_cnt_reg <= ins_cnt_next;
            sec_cnt_reg <= sec_cnt_next;
        end
    end

endmodule

/* src/ccl_out_reg.sv */
module ccl_out_reg
    import ccl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  class_beat_t  result,
    output logic         can_load,
    ccl_stream_if.source class_beat
);

    logic        valid_reg;
    class_beat_t result_reg;

    assign can_load = !valid_reg || class_beat.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && can_load)
        begin
            result_reg <= result;
        end
    end

    assign class_beat.valid   = valid_reg;
    assign class_beat.payload = result_reg;

endmodule

/* src/command_class_list_parser.sv */
// command class list parser
//
// list_beat carries one raw list byte per beat (data_byte) with last_byte set
// on the final byte of a list. class_beat carries a result beat for every
// class emitted in insecure or secure mode, and one on the final byte that
// reports both per-list totals and the truncated flag.
//
// a byte accepted is held in the input register, parsed by the combinational parse
// logic, and its result, if any, is loaded into the result register once that
// register can take it. bytes that give no result leave nothing.
// throughput: one byte per cycle while class_beat is not stalled; the parse logic
// between the input register and the result register is combinational.
//
// reset clears parse mode, pending pair and both counters, and empties both
// registers. the parser state also returns to reset after each final byte.
// when the receiver stalls, the result register holds its beat, the parse
// stage stops and the input register fills; list_beat.ready then drops until
// class_beat is taken.
module command_class_list_parser
    import ccl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    ccl_stream_if.sink   list_beat,
    ccl_stream_if.source class_beat
);

    logic        beat_valid;
    list_beat_t  beat;
    logic        can_load;
    logic        step;
    logic        emit;
    class_beat_t result;

    assign step = beat_valid && can_load;

    ccl_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .list_beat  (list_beat),
        .advance    (step),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    ccl_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .beat   (beat),
        .result (result),
        .emit   (emit)
    );

    ccl_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (step && emit),
        .result     (result),
        .can_load   (can_load),
        .class_beat (class_beat)
    );

endmodule

/* src/ccl_checker.sv */
module ccl_checker
    import ccl_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input class_beat_t out_beat
);

    // a stalled result beat stays up
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    // every result carries a class or closes a list
    a_has_reason: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_beat.class_valid || out_beat.end_of_list))
        else $error("result beat with neither class nor end of list");

    a_empty_class: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_beat.class_valid |->
            (out_beat.class_value == 16'h0000) && !out_beat.secure_class)
        else $error("class fields set on a beat without a class");

    a_trunc_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_beat.truncated |->
            out_beat.end_of_list && !out_beat.class_valid)
        else $error("truncated flag away from end of list");

endmodule

bind command_class_list_parser ccl_checker u_ccl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (class_beat.valid),
    .out_ready (class_beat.ready),
    .out_beat  (class_beat.payload)
);

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
    import ccl_pkg::*;

    // tracks the parser state and holds the result beats still to come
    class class_list_scoreboard;
        mode_t       mode;
        bit          pair_open;
        logic [7:0]  held_high;
        logic [7:0]  insecure_cnt;
        logic [7:0]  secure_cnt;
        class_beat_t pending_results[$];
        int          errors;

        function new();
            errors = 0;
            clear_list();
        endfunction

        function void clear_list();
            mode         = MODE_INSECURE;
            pair_open    = 1'b0;
            held_high    = 8'h00;
            insecure_cnt = 8'h00;
            secure_cnt   = 8'h00;
        endfunction

        function void note_byte(list_beat_t beat);
            class_beat_t res;
            bit          emit;
            bit          to_secure;
            bit          cut;
            logic [15:0] value;
            emit      = 1'b0;
            to_secure = 1'b0;
            cut       = 1'b0;
            value     = 16'h0000;
            if (pair_open) begin
                pair_open = 1'b0;
                if (beat.data_byte == SECURE_LOW) begin
                    mode = MODE_SECURE;
                end
                else begin
                    value = {held_high, beat.data_byte};
                    emit  = 1'b1;
                end
                held_high = 8'h00;
            end
            else if (beat.data_byte >= WIDE_START) begin
                // a pair opened on the final byte is dropped
                if (beat.last_byte) begin
                    cut = 1'b1;
                end
                else begin
                    pair_open = 1'b1;
                    held_high = beat.data_byte;
                end
            end
            else if (beat.data_byte == CTRL_MARK) begin
                mode = MODE_CONTROL;
            end
            else begin
                value = {8'h00, beat.data_byte};
                emit  = 1'b1;
            end

            if (emit) begin
                if (mode == MODE_INSECURE) begin
                    insecure_cnt = insecure_cnt + 8'd1;
                end
                else if (mode == MODE_SECURE) begin
                    secure_cnt = secure_cnt + 8'd1;
                    to_secure  = 1'b1;
                end
                else begin
                    emit = 1'b0;
                end
            end
            if (!emit) begin
                value     = 16'h0000;
                to_secure = 1'b0;
            end

            if (emit || beat.last_byte) begin
                res.class_value    = value;
                res.class_valid    = emit;
                res.secure_class   = to_secure;
                res.end_of_list    = beat.last_byte;
                res.insecure_total = insecure_cnt;
                res.secure_total   = secure_cnt;
                res.truncated      = cut;
                pending_results.push_back(res);
            end
            if (beat.last_byte) begin
                clear_list();
            end
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s expected %0h got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(class_beat_t got);
            class_beat_t want;
            if (pending_results.size() == 0) begin
                $error("unexpected result beat %h", got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("class_value", want.class_value, got.class_value);
            compare_field("class_valid", want.class_valid, got.class_valid);
            compare_field("secure_class", want.secure_class, got.secure_class);
            compare_field("end_of_list", want.end_of_list, got.end_of_list);
            compare_field("insecure_total", want.insecure_total, got.insecure_total);
            compare_field("secure_total", want.secure_total, got.secure_total);
            compare_field("truncated", want.truncated, got.truncated);
        endfunction
    endclass

    logic clk;
    logic rst_n;

    ccl_stream_if #(.payload_t(list_beat_t))  list_if ();
    ccl_stream_if #(.payload_t(class_beat_t)) class_if ();

    command_class_list_parser dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .list_beat  (list_if),
        .class_beat (class_if)
    );

    class_list_scoreboard board = new();

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;
    int bytes_sent    = 0;

    always begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    initial begin
        #2ms;
        $display("FAILURE");
        $finish;
    end

    // result side: check accepted beats, then pick ready for the next edge
    always @(posedge clk) begin
        if (class_if.valid && class_if.ready) begin
            board.check_result(class_if.payload);
        end
        if (!rst_n) begin
            class_if.ready <= 1'b0;
        end
        else if (hold_left > 0) begin
            class_if.ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else begin
            class_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_beat(input logic [7:0] data, input logic last);
        list_beat_t beat;
        beat.data_byte = data;
        beat.last_byte = last;
        while ($urandom_range(99) < send_idle_pct) begin
            list_if.valid <= 1'b0;
            @(posedge clk);
        end
        list_if.valid   <= 1'b1;
        list_if.payload <= beat;
        do
            @(posedge clk);
        while (!list_if.ready);
        board.note_byte(beat);
        bytes_sent++;
    endtask

    task automatic send_list(input logic [7:0] seq[$]);
        foreach (seq[i]) begin
            send_beat(seq[i], i == seq.size() - 1);
        end
    endtask

    // mostly well-formed tokens, with some raw noise and dangling pair starts
    task automatic send_random_list(input int tokens);
        logic [7:0] seq[$];
        int         kind;
        for (int t = 0; t < tokens; t++) begin
            kind = $urandom_range(99);
            if (kind < 55) begin
                seq.push_back(8'($urandom_range(0, 8'hEE)));
            end
            else if (kind < 65) begin
                seq.push_back(CTRL_MARK);
            end
            else if (kind < 90) begin
                seq.push_back(8'($urandom_range(WIDE_START, 8'hFF)));
                if ($urandom_range(2) == 0) begin
                    seq.push_back(SECURE_LOW);
                end
                else begin
                    seq.push_back(8'($urandom_range(0, 8'hFF)));
                end
            end
            else begin
                seq.push_back(8'($urandom_range(0, 8'hFF)));
            end
        end
        if ($urandom_range(6) == 0) begin
            seq.push_back(8'($urandom_range(WIDE_START, 8'hFF)));
        end
        send_list(seq);
    endtask

    // long run of plain classes so a count wraps past 255
    task automatic send_long_list(input bit secure_list);
        logic [7:0] seq[$];
        if (secure_list) begin
            seq.push_back(WIDE_START);
            seq.push_back(SECURE_LOW);
        end
        for (int i = 0; i < 262; i++) begin
            seq.push_back(8'($urandom_range(0, 8'hEE)));
        end
        send_list(seq);
    endtask

    initial begin
        int target;
        bit stalled_once;
        rst_n           = 1'b0;
        list_if.valid   = 1'b0;
        list_if.payload = '0;
        class_if.ready  = 1'b0;
        stalled_once    = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: plain, wide, control, secure marker, pair data bytes, dangling start
        send_list('{8'h00, 8'h01, 8'hEE, 8'hF0, 8'hFF, 8'hFF, 8'hF1, 8'h01, CTRL_MARK,
                    8'h20, 8'hF2, 8'h34, WIDE_START, SECURE_LOW, 8'h5A, 8'hF3, CTRL_MARK,
                    8'hF1, 8'hF1, CTRL_MARK, 8'hF4, SECURE_LOW, 8'hF5});
        send_list('{8'h00});
        send_list('{CTRL_MARK});
        send_list('{WIDE_START, SECURE_LOW});

        bytes_sent = 0;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 22; recv_idle_pct = 48; end
                1: begin send_idle_pct = 48; recv_idle_pct = 22; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            if (phase == 2) begin
                send_long_list(1'b1);
            end
            target = (phase < 2) ? 143 * (phase + 1) : 550;
            while (bytes_sent < target) begin
                if (phase == 0 && bytes_sent > 40 && !stalled_once) begin
                    hold_left    = 150;
                    stalled_once = 1'b1;
                end
                send_random_list($urandom_range(1, 12));
            end
        end
        list_if.valid <= 1'b0;

        while (board.pending_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);

        if (board.errors == 0) begin
            $display("SUCCESS");
        end
        else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
